/* rtl/seebp_pkg.sv */
// Package for the serial bit-banged byte store: widths, port addresses,
// command codes, pin command struct and the answer table function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package seebp_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int ROM_DEPTH   = 512;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int ROM_IDX_W   = $clog2(ROM_DEPTH);
  localparam int ROM_W       = 10;
  localparam int PHASE_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int VARIANT_W   = 3;

  localparam logic [ADDR_W-1:0]    PIN_ADDR_V0 = 16'h5301;
  localparam logic [ADDR_W-1:0]    PIN_ADDR_V1 = 16'h5601;
  localparam logic [VARIANT_W-1:0] VARIANT_V0  = 3'd0;
  localparam logic [VARIANT_W-1:0] VARIANT_V1  = 3'd1;

  localparam int SEL_BIT_V0 = 2;
  localparam int SEL_BIT_V1 = 4;
  localparam int CLK_BIT    = 1;
  localparam int DAT_BIT    = 0;

  localparam logic [3:0] CMD_READ  = 4'h5;
  localparam logic [3:0] CMD_WRITE = 4'hA;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [BYTE_W-1:0] RD_BIT_SET  = 8'h80;
  localparam logic [BYTE_W-1:0] RD_BIT_CLR  = 8'h00;
  localparam logic [BYTE_W-1:0] RD_OPEN_BUS = 8'hFF;
  localparam logic [BYTE_W-1:0] WR_RESULT   = 8'h00;

  typedef struct packed {
    logic drive;
    logic sel;
    logic clk;
    logic dat;
  } pin_cmd_t;

  // answer table: mostly index plus a small offset, with a few entries pulled out
  function automatic logic [ROM_W-1:0] answer_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [3:0]       off;
    logic [ROM_W-1:0] w;
    if (idx < 9'd66)       off = 4'd7;
    else if (idx < 9'd86)  off = 4'd5;
    else if (idx < 9'd126) off = 4'd4;
    else if (idx < 9'd138) off = 4'd2;
    else if (idx < 9'd236) off = 4'd1;
    else if (idx < 9'd253) off = 4'd2;
    else if (idx < 9'd254) off = 4'd3;
    else if (idx < 9'd346) off = 4'd2;
    else if (idx < 9'd506) off = 4'd3;
    else                   off = 4'd6;
    w = {1'b0, idx} + ROM_W'(off);
    case (idx)
      9'd66:   w = 10'd0;
      9'd67:   w = 10'd1;
      9'd86:   w = 10'd4;
      9'd126:  w = 10'd2;
      9'd127:  w = 10'd3;
      9'd138:  w = 10'd5;
      9'd254:  w = 10'd6;
      default: ;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/seebp_if.sv */
// Valid/ready channel interfaces for bus access items and read result items.
// Depends on seebp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface seebp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [seebp_pkg::ADDR_W-1:0]   address;
  logic [seebp_pkg::BYTE_W-1:0]   write_data;

  modport source(output valid, action, address, write_data, input ready);
  modport sink(input valid, action, address, write_data, output ready);
endinterface

interface seebp_out_if;
  logic                           valid;
  logic                           ready;
  logic [seebp_pkg::BYTE_W-1:0]   read_data;

  modport source(output valid, read_data, input ready);
  modport sink(input valid, read_data, output ready);
endinterface
`default_nettype wire

/* rtl/seebp_core.sv */
// Serial protocol engine: clock edge detect, bit counter, command shift,
// sixteen byte store and answer bit lookup. Depends on seebp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module seebp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire seebp_pkg::pin_cmd_t pin_i,
  output logic                    sout_o
);

  logic [seebp_pkg::BYTE_W-1:0]  store_r   [seebp_pkg::STORE_DEPTH];
  logic [seebp_pkg::BYTE_W-1:0]  store_nxt [seebp_pkg::STORE_DEPTH];
  logic                          last_clk_r, last_clk_nxt;
  logic [seebp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [seebp_pkg::BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic                          sout_r, sout_nxt;

  logic [seebp_pkg::SLOT_W-1:0]    slot;
  logic [2:0]                      bitpos;
  logic [seebp_pkg::BYTE_W-1:0]    wr_byte;
  logic [seebp_pkg::BYTE_W-1:0]    b0, b1, b2;
  logic [seebp_pkg::ROM_IDX_W-1:0] rom_idx;
  logic [seebp_pkg::ROM_W-1:0]     rom_word;
  logic [seebp_pkg::BYTE_W-1:0]    ans_byte;
  logic                            rise;

  assign slot   = cmd_r[seebp_pkg::SLOT_W-1:0];
  assign bitpos = ~phase_r[2:0];
  assign rise   = !last_clk_r && pin_i.clk;

  always_comb begin
    wr_byte         = store_r[slot];
    wr_byte[bitpos] = pin_i.dat;
  end

  // table index is taken from the store as it stands after this bit lands
  assign b0       = (slot == seebp_pkg::SLOT_W'(0)) ? wr_byte : store_r[0];
  assign b1       = (slot == seebp_pkg::SLOT_W'(1)) ? wr_byte : store_r[1];
  assign b2       = (slot == seebp_pkg::SLOT_W'(2)) ? wr_byte : store_r[2];
  assign rom_idx  = {b2[0], b0 | b1};
  assign rom_word = seebp_pkg::answer_rom(rom_idx);
  assign ans_byte = slot[0] ? rom_word[seebp_pkg::BYTE_W-1:0]
                            : {{(2*seebp_pkg::BYTE_W-seebp_pkg::ROM_W){1'b0}},
                               rom_word[seebp_pkg::ROM_W-1:seebp_pkg::BYTE_W]};

  always_comb begin
    store_nxt    = store_r;
    last_clk_nxt = last_clk_r;
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    sout_nxt     = sout_r;
    if (pin_i.drive) begin
      last_clk_nxt = pin_i.clk;
      if (pin_i.sel) begin
        phase_nxt = '0;
      end else if (rise) begin
        if (!phase_r[3]) begin
          cmd_nxt   = {cmd_r[seebp_pkg::BYTE_W-2:0], pin_i.dat};
          phase_nxt = phase_r + 1'b1;
          // only read and write commands go on to the data bits
          if (phase_r == 4'd7 && cmd_nxt[7:4] != seebp_pkg::CMD_READ &&
              cmd_nxt[7:4] != seebp_pkg::CMD_WRITE) begin
            phase_nxt = '0;
          end
        end else begin
          if (cmd_r[7:4] == seebp_pkg::CMD_WRITE) begin
            store_nxt[slot] = wr_byte;
            sout_nxt        = ans_byte[bitpos];
          end else if (cmd_r[7:4] == seebp_pkg::CMD_READ) begin
            sout_nxt = store_r[slot][bitpos];
          end
          // wraps to zero after the last data bit
          phase_nxt = phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < seebp_pkg::STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
      last_clk_r <= 1'b1;
      phase_r    <= '0;
      cmd_r      <= '0;
      sout_r     <= 1'b1;
    end else begin
      store_r    <= store_nxt;
      last_clk_r <= last_clk_nxt;
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      sout_r     <= sout_nxt;
    end
  end

  assign sout_o = sout_r;

  a_data_phase_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[3] |-> (cmd_r[7:4] == seebp_pkg::CMD_READ || cmd_r[7:4] == seebp_pkg::CMD_WRITE))
    else $error("data phase with a rejected command");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pin_i.drive |=> $stable(phase_r) && $stable(sout_r) && $stable(cmd_r))
    else $error("protocol state moved without a pin write");

  a_select_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pin_i.drive && pin_i.sel) |=> (phase_r == '0))
    else $error("select did not clear the bit counter");

endmodule
`default_nettype wire

/* rtl/serial_eeprom_bit_protocol_top.sv */
// Top level of the serial bit-banged byte store: input register, bus decode,
// protocol engine and result register. Depends on seebp_pkg, seebp_if, seebp_core.
// Items are held in the input register, their results in the result register.
// Throughput: one item per cycle unless the output stalls; the input and result
// registers let a new item enter while a finished result waits on the output.
// Reset (rst_n low, synchronous): both channels empty, store cleared to zero,
// bit counter and command cleared, clock latch and output bit set, variant zero.
`timescale 1ns / 1ps
`default_nettype none
module serial_eeprom_bit_protocol_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  seebp_in_if.sink                               in_chan,
  seebp_out_if.source                            out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [seebp_pkg::VARIANT_W-1:0]   cfg_wdata
);

  logic [seebp_pkg::VARIANT_W-1:0] variant_r;

  logic                         in_valid_r, in_valid_nxt;
  logic                         act_r;
  logic [seebp_pkg::ADDR_W-1:0] addr_r;
  logic [seebp_pkg::BYTE_W-1:0] wdata_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [seebp_pkg::BYTE_W-1:0] rdata_r, rdata_nxt;

  logic                         in_fire, adv, sout;
  logic                         hit_v0, hit_v1;
  seebp_pkg::pin_cmd_t          pin;

  assign adv           = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign hit_v0 = (addr_r == seebp_pkg::PIN_ADDR_V0) && (variant_r == seebp_pkg::VARIANT_V0);
  assign hit_v1 = (addr_r == seebp_pkg::PIN_ADDR_V1) && (variant_r == seebp_pkg::VARIANT_V1);

  always_comb begin
    pin.drive = adv && (act_r == seebp_pkg::ACT_WRITE) && (hit_v0 || hit_v1);
    pin.sel   = hit_v0 ? wdata_r[seebp_pkg::SEL_BIT_V0] : wdata_r[seebp_pkg::SEL_BIT_V1];
    pin.clk   = wdata_r[seebp_pkg::CLK_BIT];
    pin.dat   = wdata_r[seebp_pkg::DAT_BIT];
  end

  seebp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .pin_i  (pin),
    .sout_o (sout)
  );

  // reads see the output bit left by every earlier item
  always_comb begin
    if (act_r == seebp_pkg::ACT_WRITE) begin
      rdata_nxt = seebp_pkg::WR_RESULT;
    end else if (addr_r == seebp_pkg::PIN_ADDR_V0 || addr_r == seebp_pkg::PIN_ADDR_V1) begin
      rdata_nxt = sout ? seebp_pkg::RD_BIT_SET : seebp_pkg::RD_BIT_CLR;
    end else begin
      rdata_nxt = seebp_pkg::RD_OPEN_BUS;
    end
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= seebp_pkg::VARIANT_V0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        variant_r <= cfg_wdata;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= in_chan.action;
      addr_r  <= in_chan.address;
      wdata_r <= in_chan.write_data;
    end
    if (adv) begin
      rdata_r <= rdata_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = rdata_r;

  a_adv_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed item produced no result");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted item not held in the input register");

  a_pins_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    pin.drive |-> (act_r == seebp_pkg::ACT_WRITE && in_valid_r))
    else $error("pin update without a write item");

endmodule
`default_nettype wire

/* dv/tb_serial_eeprom_bit_protocol_top.sv */
// Self-checking bench for the serial bit-banged byte store behind bus accesses.
// Drives pin-port frames and bus noise, predicts every read_data in order.
// Depends on seebp_pkg, seebp_if and serial_eeprom_bit_protocol_top.
`timescale 1ns / 1ps
module tb_serial_eeprom_bit_protocol_top;

  localparam int LATENCY     = 2;
  localparam int HOLD_CYCLES = 50;
  localparam int IDLE_PCT    = 27;
  localparam int RAND_ITEMS  = 96;
  localparam int NO_SELECT   = 16;
  localparam logic [seebp_pkg::VARIANT_W-1:0] VARIANT_NONE_LO = 3'd2;
  localparam logic [seebp_pkg::VARIANT_W-1:0] VARIANT_TOP     = 3'd5;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [seebp_pkg::VARIANT_W-1:0] cfg_wdata;

  seebp_in_if  in_chan ();
  seebp_out_if out_chan ();

  serial_eeprom_bit_protocol_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // predictor state
  logic [seebp_pkg::BYTE_W-1:0]    eeprom_bytes [seebp_pkg::STORE_DEPTH];
  logic                            clk_pin_q;
  logic [seebp_pkg::PHASE_W-1:0]   bit_count;
  logic [seebp_pkg::BYTE_W-1:0]    cmd_shift;
  logic                            dout_bit;
  logic [seebp_pkg::VARIANT_W-1:0] model_variant;
  logic [seebp_pkg::ROM_W-1:0]     answer_words [seebp_pkg::ROM_DEPTH];

  logic [seebp_pkg::BYTE_W-1:0] expected_reads [$];
  int                mismatches;
  int                items_sent;
  logic [seebp_pkg::VARIANT_W-1:0] cur_variant;
  logic              no_idle;
  logic              long_hold;
  int                hold_cnt;

  // answer table: ascending run from 7 with a few values skipped,
  // seven entries carry the small values instead
  initial begin : fill_answers
    int unsigned nxt;
    nxt = 7;
    for (int i = 0; i < seebp_pkg::ROM_DEPTH; i++) begin
      case (i)
        66:  answer_words[i] = 10'd0;
        67:  answer_words[i] = 10'd1;
        86:  answer_words[i] = 10'd4;
        126: answer_words[i] = 10'd2;
        127: answer_words[i] = 10'd3;
        138: answer_words[i] = 10'd5;
        254: answer_words[i] = 10'd6;
        default: begin
          while (nxt == 237 || nxt == 255 || nxt == 348 || (nxt >= 509 && nxt <= 511))
            nxt++;
          answer_words[i] = seebp_pkg::ROM_W'(nxt);
          nxt++;
        end
      endcase
    end
  end

  function automatic void model_reset();
    foreach (eeprom_bytes[i]) eeprom_bytes[i] = '0;
    clk_pin_q     = 1'b1;
    bit_count     = '0;
    cmd_shift     = '0;
    dout_bit      = 1'b1;
    model_variant = seebp_pkg::VARIANT_V0;
  endfunction

  function automatic void pins_update(input logic sel, input logic sclk, input logic dat);
    logic [2:0]                      bpos;
    logic [seebp_pkg::SLOT_W-1:0]    slot;
    logic [seebp_pkg::ROM_IDX_W-1:0] idx;
    logic [seebp_pkg::ROM_W-1:0]     word;
    if (sel) begin
      bit_count = '0;
    end else if (!clk_pin_q && sclk) begin
      if (bit_count < 8) begin
        cmd_shift = {cmd_shift[6:0], dat};
        bit_count = bit_count + 1'b1;
        if (bit_count == 8 && cmd_shift[7:4] != seebp_pkg::CMD_READ &&
            cmd_shift[7:4] != seebp_pkg::CMD_WRITE)
          bit_count = '0;
      end else begin
        bpos = 3'(15 - bit_count);
        slot = cmd_shift[3:0];
        if (cmd_shift[7:4] == seebp_pkg::CMD_WRITE) begin
          eeprom_bytes[slot][bpos] = dat;
          idx  = {eeprom_bytes[2][0], eeprom_bytes[0] | eeprom_bytes[1]};
          word = answer_words[idx];
          // even byte address takes the upper part of the answer word
          if (!slot[0]) word = word >> 8;
          dout_bit = word[bpos];
        end else if (cmd_shift[7:4] == seebp_pkg::CMD_READ) begin
          dout_bit = eeprom_bytes[slot][bpos];
        end
        if (bit_count == 15) bit_count = '0;
        else bit_count = bit_count + 1'b1;
      end
    end
    clk_pin_q = sclk;
  endfunction

  function automatic logic [seebp_pkg::BYTE_W-1:0] model_access(
      input logic act,
      input logic [seebp_pkg::ADDR_W-1:0] addr,
      input logic [seebp_pkg::BYTE_W-1:0] data);
    if (act == seebp_pkg::ACT_READ) begin
      if (addr == seebp_pkg::PIN_ADDR_V0 || addr == seebp_pkg::PIN_ADDR_V1)
        return dout_bit ? seebp_pkg::RD_BIT_SET : seebp_pkg::RD_BIT_CLR;
      return seebp_pkg::RD_OPEN_BUS;
    end
    if (addr == seebp_pkg::PIN_ADDR_V0 && model_variant == seebp_pkg::VARIANT_V0)
      pins_update(data[seebp_pkg::SEL_BIT_V0], data[seebp_pkg::CLK_BIT],
                  data[seebp_pkg::DAT_BIT]);
    else if (addr == seebp_pkg::PIN_ADDR_V1 && model_variant == seebp_pkg::VARIANT_V1)
      pins_update(data[seebp_pkg::SEL_BIT_V1], data[seebp_pkg::CLK_BIT],
                  data[seebp_pkg::DAT_BIT]);
    return seebp_pkg::WR_RESULT;
  endfunction

  // results are checked before the same edge's item is predicted
  always @(posedge clk) begin : scoreboard
    logic [seebp_pkg::BYTE_W-1:0] want;
    if (!rst_n) begin
      model_reset();
      expected_reads.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual read_data %02h",
                   $time, out_chan.read_data);
          mismatches++;
        end else begin
          want = expected_reads.pop_front();
          if (out_chan.read_data !== want) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want, out_chan.read_data);
            mismatches++;
          end
        end
      end
      if (cfg_we) model_variant = cfg_wdata;
      if (in_chan.valid && in_chan.ready)
        expected_reads.push_back(model_access(in_chan.action, in_chan.address,
                                              in_chan.write_data));
    end
  end

  // result side: random stalls, or one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_chan.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      if (!long_hold) hold_cnt <= 0;
      out_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_access(input logic act, input logic [seebp_pkg::ADDR_W-1:0] addr,
                             input logic [seebp_pkg::BYTE_W-1:0] data);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.address    <= addr;
    in_chan.write_data <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // one edge first so the last accepted item is already queued
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
  endtask

  task automatic set_variant(input logic [seebp_pkg::VARIANT_W-1:0] v);
    wait_drain();
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_variant = v;
  endtask

  function automatic logic [seebp_pkg::ADDR_W-1:0] any_port();
    return $urandom_range(0, 1) ? seebp_pkg::PIN_ADDR_V1 : seebp_pkg::PIN_ADDR_V0;
  endfunction

  task automatic pin_write(input logic sel, input logic sclk, input logic dat);
    logic [seebp_pkg::BYTE_W-1:0] d;
    logic [seebp_pkg::ADDR_W-1:0] a;
    d = seebp_pkg::BYTE_W'($urandom_range(0, 255));
    if (cur_variant == seebp_pkg::VARIANT_V0) begin
      a = seebp_pkg::PIN_ADDR_V0;
      d[seebp_pkg::SEL_BIT_V0] = sel;
    end else if (cur_variant == seebp_pkg::VARIANT_V1) begin
      a = seebp_pkg::PIN_ADDR_V1;
      d[seebp_pkg::SEL_BIT_V1] = sel;
    end else begin
      a = any_port();
      d[seebp_pkg::SEL_BIT_V0] = sel;
      d[seebp_pkg::SEL_BIT_V1] = sel;
    end
    d[seebp_pkg::CLK_BIT] = sclk;
    d[seebp_pkg::DAT_BIT] = dat;
    send_access(seebp_pkg::ACT_WRITE, a, d);
  endtask

  task automatic read_port();
    send_access(seebp_pkg::ACT_READ, any_port(), seebp_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // select, then 16 clocked bits msb first; select may be raised again mid-frame
  task automatic send_frame(input logic [seebp_pkg::BYTE_W-1:0] cmd,
                            input logic [seebp_pkg::BYTE_W-1:0] dat,
                            input int peek_pct, input int select_at);
    logic b;
    pin_write(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < 16; i++) begin
      if (i == select_at) pin_write(1'b1, 1'b1, 1'($urandom_range(0, 1)));
      b = (i < 8) ? cmd[7 - i] : dat[15 - i];
      pin_write(1'b0, 1'b0, b);
      pin_write(1'b0, 1'b1, b);
      // clock held high: no new edge
      if ($urandom_range(0, 99) < 5) pin_write(1'b0, 1'b1, ~b);
      if ($urandom_range(0, 99) < peek_pct) read_port();
    end
  endtask

  task automatic test_bus_decode();
    send_access(seebp_pkg::ACT_READ, 16'h0000, 8'h00);
    send_access(seebp_pkg::ACT_READ, 16'hFFFF, 8'hFF);
    send_access(seebp_pkg::ACT_READ, seebp_pkg::PIN_ADDR_V0, 8'h00);
    send_access(seebp_pkg::ACT_READ, seebp_pkg::PIN_ADDR_V1, 8'hFF);
    send_access(seebp_pkg::ACT_READ, seebp_pkg::PIN_ADDR_V0 - 1'b1, 8'h55);
    send_access(seebp_pkg::ACT_READ, seebp_pkg::PIN_ADDR_V1 + 1'b1, 8'hAA);
    send_access(seebp_pkg::ACT_WRITE, 16'h0000, 8'h00);
    send_access(seebp_pkg::ACT_WRITE, 16'hFFFF, 8'hFF);
    // wrong port for this variant
    send_access(seebp_pkg::ACT_WRITE, seebp_pkg::PIN_ADDR_V1, 8'hFF);
    send_access(seebp_pkg::ACT_WRITE, seebp_pkg::PIN_ADDR_V0, 8'h04);
    send_access(seebp_pkg::ACT_READ, seebp_pkg::PIN_ADDR_V1, 8'h00);
  endtask

  task automatic test_store_frames();
    send_frame({seebp_pkg::CMD_WRITE, 4'd2}, 8'h01, 25, NO_SELECT);
    send_frame({seebp_pkg::CMD_WRITE, 4'd1}, 8'h5A, 25, NO_SELECT);
    send_frame({seebp_pkg::CMD_READ, 4'd1}, 8'h00, 100, NO_SELECT);
  endtask

  task automatic test_rejected_commands();
    send_frame(8'h6A, 8'h4F, 25, NO_SELECT);
    send_frame({seebp_pkg::CMD_WRITE, 4'd0}, 8'hC3, 25, 11);
  endtask

  task automatic test_output_stall();
    long_hold <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) read_port();
      else pin_write(1'b0, 1'(i % 2), 1'($urandom_range(0, 1)));
    end
    long_hold <= 1'b0;
    wait_drain();
  endtask

  task automatic random_phase(input logic [seebp_pkg::VARIANT_W-1:0] v, input int quota,
                              input logic steady);
    int start;
    int r;
    set_variant(v);
    no_idle <= steady;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame({$urandom_range(0, 1) ? seebp_pkg::CMD_READ : seebp_pkg::CMD_WRITE,
                    4'($urandom_range(0, 15))},
                   seebp_pkg::BYTE_W'($urandom_range(0, 255)), 40,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : NO_SELECT);
      end else if (r < 85) begin
        send_frame(seebp_pkg::BYTE_W'($urandom_range(0, 255)),
                   seebp_pkg::BYTE_W'($urandom_range(0, 255)), 30, NO_SELECT);
      end else begin
        repeat ($urandom_range(1, 4))
          send_access(1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? seebp_pkg::ADDR_W'($urandom_range(0, 65535))
                                           : any_port(),
                      seebp_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
    no_idle <= 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(seebp_pkg::VARIANT_V1, RAND_ITEMS * 3 / 8, 1'b0);
    random_phase(seebp_pkg::VARIANT_V0, RAND_ITEMS * 3 / 8, 1'b1);
    random_phase(VARIANT_TOP, RAND_ITEMS / 8, 1'b0);
    random_phase(VARIANT_NONE_LO, RAND_ITEMS / 8, 1'b0);
    random_phase(seebp_pkg::VARIANT_V0, RAND_ITEMS / 8, 1'b0);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.action     = seebp_pkg::ACT_READ;
    in_chan.address    = '0;
    in_chan.write_data = '0;
    no_idle            = 1'b0;
    long_hold          = 1'b0;
    mismatches         = 0;
    items_sent         = 0;
    cur_variant        = seebp_pkg::VARIANT_V0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_variant(seebp_pkg::VARIANT_V0);
    test_bus_decode();
    test_store_frames();
    test_rejected_commands();
    test_output_stall();
    test_random_traffic();

    wait_drain();
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0 && expected_reads.size() == 0)
      $display("serial_eeprom_bit_protocol_top regression: pass");
    else
      $display("serial_eeprom_bit_protocol_top regression: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("serial_eeprom_bit_protocol_top regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/seebp_pkg.sv
rtl/seebp_if.sv
rtl/seebp_core.sv
rtl/serial_eeprom_bit_protocol_top.sv
dv/tb_serial_eeprom_bit_protocol_top.sv
